@@ design/rvma_pkg.sv @@
// ---------------------------------------------------------------------------
// rvma_pkg
// Shared widths, register map, reset values and types for the streamed
// row vector by matrix accumulator.
// ---------------------------------------------------------------------------
package rvma_pkg;

    // Defaults for the top level parameters
    localparam int unsigned MAX_COLS_DEF  = 1024;
    localparam int unsigned ACC_WIDTH_DEF = 48;

    // Payload widths
    localparam int unsigned VEC_W    = 16;
    localparam int unsigned MAT_W    = 16;
    localparam int unsigned PROD_W   = VEC_W + MAT_W;
    localparam int unsigned SUM_W    = 48;
    localparam int unsigned COLIDX_W = 10;

    // Register widths and reset values
    localparam int unsigned ROWS_W = 16;
    localparam int unsigned COLS_W = 11;
    localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(1);
    localparam logic [COLS_W-1:0] COLS_RST = COLS_W'(1);

    // Configuration bus
    localparam int unsigned APB_DW      = 32;
    localparam int unsigned APB_AW      = 3;
    localparam int unsigned REG_SEL_BIT = 2;

    // Register index, decoded from the word address
    typedef enum logic [0:0] {
        REG_ROWS_IN_USE = 1'b0,
        REG_COLS_IN_USE = 1'b1
    } t_reg_sel;

    // Live configuration handed to the datapath
    typedef struct packed {
        logic [ROWS_W-1:0] rows_in_use;
        logic [COLS_W-1:0] cols_in_use;
    } t_cfg;

endpackage

@@ design/rvma_vec_if.sv @@
// ---------------------------------------------------------------------------
// rvma_vec_if
// Input channel: one vector element and one matrix element per word.
// ---------------------------------------------------------------------------
interface rvma_vec_if;
    import rvma_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] vec_value;
    logic signed [MAT_W-1:0] mat_value;

    modport source (output valid, output vec_value, output mat_value, input ready);
    modport sink   (input valid, input vec_value, input mat_value, output ready);
endinterface

@@ design/rvma_res_if.sv @@
// ---------------------------------------------------------------------------
// rvma_res_if
// Result channel: one finished column sum per word.
// ---------------------------------------------------------------------------
interface rvma_res_if;
    import rvma_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [COLIDX_W-1:0]     col_index;
    logic signed [SUM_W-1:0] sum;
    logic                    saturated;
    logic                    last;

    modport source (output valid, output col_index, output sum, output saturated,
                    output last, input ready);
    modport sink   (input valid, input col_index, input sum, input saturated,
                    input last, output ready);
endinterface

@@ design/rvma_cfg.sv @@
// ---------------------------------------------------------------------------
// rvma_cfg
// APB register file holding the row and column counts, with readback.
// ---------------------------------------------------------------------------
module rvma_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rvma_pkg::APB_AW-1:0] paddr,
    input  logic [rvma_pkg::APB_DW-1:0] pwdata,
    output logic [rvma_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output rvma_pkg::t_cfg              o_cfg
);
    import rvma_pkg::*;

    logic [ROWS_W-1:0] r_rows_in_use;
    logic [COLS_W-1:0] r_cols_in_use;
    logic              wr_en;
    t_reg_sel          reg_sel;

    // Zero wait state bus
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = t_reg_sel'(paddr[REG_SEL_BIT]);

    // Update the selected register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RST;
            r_cols_in_use <= COLS_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ROWS_IN_USE: r_rows_in_use <= pwdata[ROWS_W-1:0];
                REG_COLS_IN_USE: r_cols_in_use <= pwdata[COLS_W-1:0];
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (reg_sel)
            REG_ROWS_IN_USE: prdata = APB_DW'(r_rows_in_use);
            REG_COLS_IN_USE: prdata = APB_DW'(r_cols_in_use);
        endcase
    end

    assign o_cfg.rows_in_use = r_rows_in_use;
    assign o_cfg.cols_in_use = r_cols_in_use;

endmodule

@@ design/rvma_acc_mem.sv @@
// ---------------------------------------------------------------------------
// rvma_acc_mem
// Column accumulator store: one write and one registered read per cycle,
// swept to zero after reset.
// ---------------------------------------------------------------------------
module rvma_acc_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 49
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic                     o_busy
);
    import rvma_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_clr_addr;
    logic             r_clearing;
    logic             we;
    logic [AW-1:0]    wa;
    logic [WIDTH-1:0] wd;

    // Sweep every entry to zero once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Clear sweep owns the write port while it runs
    assign we = r_clearing || i_wr_en;
    assign wa = r_clearing ? r_clr_addr : i_wr_addr;
    assign wd = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_busy = r_clearing;

endmodule

@@ design/row_vector_matrix_accumulate.sv @@
// ---------------------------------------------------------------------------
// row_vector_matrix_accumulate
// Streamed row vector times matrix product with saturating per-column
// accumulators; each word of the last row emits that column's final sum.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake              Word
//  i_vec    in   valid/ready            vec_value Q1.15, mat_value Q4.12
//  o_res    out  valid/ready            col_index, sum Q21.27, saturated, last
//  APB      in   psel/penable, pready   rows_in_use @0x0, cols_in_use @0x4
//
//  One input word per cycle sustained after the clear sweep while o_res
//  is not stalled. A taken word passes through the product stage, which
//  registers the product and the accumulator read; a last-row word then
//  goes on to the result register, which loads the saturating add.
//  After reset the accumulator memory is swept to zero, during which
//  i_vec.ready stays low; registers can be written meanwhile.
//  A stalled o_res holds a last-row word in the add stage, which then holds
//  i_vec.ready low.
// ---------------------------------------------------------------------------
module row_vector_matrix_accumulate #(
    parameter int unsigned MAX_COLS  = rvma_pkg::MAX_COLS_DEF,
    parameter int unsigned ACC_WIDTH = rvma_pkg::ACC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rvma_vec_if.sink                    i_vec,
    rvma_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rvma_pkg::APB_AW-1:0] paddr,
    input  logic [rvma_pkg::APB_DW-1:0] pwdata,
    output logic [rvma_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import rvma_pkg::*;

    localparam int unsigned COL_W  = $clog2(MAX_COLS);
    localparam int unsigned ECNT_W = (COL_W + 1 > COLS_W) ? COL_W + 1 : COLS_W;
    localparam int unsigned MEM_W  = ACC_WIDTH + 1;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    t_cfg cfg;

    // Position counters
    logic [COL_W-1:0]  r_col_pos;
    logic [ROWS_W-1:0] r_row_pos;

    // Product stage
    logic                     r_s1_valid;
    logic [COL_W-1:0]         r_s1_col;
    logic signed [PROD_W-1:0] r_s1_prod;
    logic                     r_s1_last_row;
    logic                     r_s1_last_col;

    // Last memory write, for read-during-write forwarding
    logic             r_wb_valid;
    logic [COL_W-1:0] r_wb_col;
    logic [MEM_W-1:0] r_wb_data;

    // Result register
    logic                    r_out_valid;
    logic [COLIDX_W-1:0]     r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_sat;
    logic                    r_out_last;

    logic                        accept;
    logic                        s1_adv;
    logic                        out_free;
    logic                        mem_busy;
    logic [MEM_W-1:0]            mem_rdata;
    logic [ECNT_W-1:0]           ecols;
    logic [ECNT_W-1:0]           ecols_m1;
    logic [ROWS_W-1:0]           erows_m1;
    logic                        last_col;
    logic                        last_row;
    logic [MEM_W-1:0]            old_entry;
    logic signed [ACC_WIDTH-1:0] old_acc;
    logic signed [ACC_WIDTH:0]   acc_wide;
    logic                        acc_ovf;
    logic signed [ACC_WIDTH-1:0] new_acc;
    logic                        new_sat;
    logic signed [SUM_W-1:0]     out_sum;
    logic                        out_clamp;
    logic [MEM_W-1:0]            wr_data;

    rvma_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Effective counts: zero acts as one, columns capped at the store depth
    always_comb begin
        ecols = ECNT_W'(cfg.cols_in_use);
        if (ecols == '0) begin
            ecols = ECNT_W'(1);
        end
        if (ecols > ECNT_W'(MAX_COLS)) begin
            ecols = ECNT_W'(MAX_COLS);
        end
        ecols_m1 = ecols - ECNT_W'(1);
        erows_m1 = (cfg.rows_in_use == '0) ? '0 : cfg.rows_in_use - ROWS_W'(1);
    end

    assign last_col = ECNT_W'(r_col_pos) >= ecols_m1;
    assign last_row = r_row_pos >= erows_m1;

    // Handshake
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_adv      = r_s1_valid && (!r_s1_last_row || out_free);
    assign i_vec.ready = !mem_busy && (!r_s1_valid || s1_adv);
    assign accept      = i_vec.valid && i_vec.ready;

    // Advance row and column positions on each taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col_pos <= '0;
                r_row_pos <= last_row ? '0 : r_row_pos + ROWS_W'(1);
            end else begin
                r_col_pos <= r_col_pos + COL_W'(1);
            end
        end
    end

    // Product stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture product and position
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= r_col_pos;
            r_s1_prod     <= i_vec.vec_value * i_vec.mat_value;
            r_s1_last_row <= last_row;
            r_s1_last_col <= last_col;
        end
    end

    rvma_acc_mem #(
        .DEPTH (MAX_COLS),
        .WIDTH (MEM_W)
    ) u_acc_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_col_pos),
        .o_rd_data (mem_rdata),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data),
        .o_busy    (mem_busy)
    );

    // Take the newest copy of the column entry
    assign old_entry = (r_wb_valid && r_wb_col == r_s1_col) ? r_wb_data : mem_rdata;
    assign old_acc   = old_entry[ACC_WIDTH-1:0];

    // Saturating accumulate
    always_comb begin
        acc_wide = (ACC_WIDTH+1)'(old_acc) + (ACC_WIDTH+1)'(r_s1_prod);
        acc_ovf  = acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1];
        if (acc_ovf) begin
            new_acc = acc_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            new_acc = acc_wide[ACC_WIDTH-1:0];
        end
        new_sat = old_entry[ACC_WIDTH] || acc_ovf;
    end

    // Clamp the emitted sum to the result width
    generate
        if (ACC_WIDTH > SUM_W) begin : g_out_clamp
            logic [ACC_WIDTH-SUM_W:0] hi_bits;
            logic                     fits;
            assign hi_bits   = new_acc[ACC_WIDTH-1:SUM_W-1];
            assign fits      = (&hi_bits) || !(|hi_bits);
            assign out_clamp = !fits;
            assign out_sum   = fits ? new_acc[SUM_W-1:0]
                             : (new_acc[ACC_WIDTH-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                     : {1'b0, {(SUM_W-1){1'b1}}});
        end else begin : g_out_ext
            assign out_clamp = 1'b0;
            assign out_sum   = SUM_W'(new_acc);
        end
    endgenerate

    // Drop the column entry back to zero once its sum goes out
    assign wr_data = r_s1_last_row ? '0 : {new_sat, new_acc};

    // Track the last write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (s1_adv) begin
            r_wb_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_wb_col  <= r_s1_col;
            r_wb_data <= wr_data;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last_row) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last_row) begin
            r_out_col  <= COLIDX_W'(r_s1_col);
            r_out_sum  <= out_sum;
            r_out_sat  <= new_sat || out_clamp;
            r_out_last <= r_s1_last_col;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.col_index = r_out_col;
    assign o_res.sum       = r_out_sum;
    assign o_res.saturated = r_out_sat;
    assign o_res.last      = r_out_last;

endmodule

@@ design/rvma_checker.sv @@
// ---------------------------------------------------------------------------
// rvma_checker
// Port-level checks on the accumulator: result hold under stall, the reset
// sweep, and register readback.
// ---------------------------------------------------------------------------
module rvma_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [rvma_pkg::COLIDX_W-1:0] i_out_col,
    input logic [rvma_pkg::SUM_W-1:0]  i_out_sum,
    input logic                        i_psel,
    input logic                        i_penable,
    input logic                        i_pwrite,
    input logic [rvma_pkg::APB_AW-1:0] i_paddr,
    input logic [rvma_pkg::APB_DW-1:0] i_pwdata,
    input logic [rvma_pkg::APB_DW-1:0] i_prdata
);
    import rvma_pkg::*;

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its column and sum
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_col) && $stable(i_out_sum))
        else $error("result word changed while stalled");

    // No input taken on the first cycle of the clear sweep
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("input ready during accumulator clear");

    // Column count reads back what was written
    a_cols_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && i_paddr[REG_SEL_BIT]
        |=> !i_paddr[REG_SEL_BIT] || i_prdata[COLS_W-1:0] == $past(i_pwdata[COLS_W-1:0]))
        else $error("cols_in_use readback mismatch");

endmodule

bind row_vector_matrix_accumulate rvma_checker u_rvma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_col   (o_res.col_index),
    .i_out_sum   (o_res.sum),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);
